// ----- sv/wrrs_pkg.sv -----
// Package for the weighted ROC AUC rank-sum block.
// Holds sizes, widths and the command and status structs; depends on nothing.
package wrrs_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int TOT_W      = COUNT_BITS + CNT_W;
  localparam int U_W        = 2 * TOT_W;
  localparam int FRAC_W     = 17;
  localparam int STEP_W     = $clog2(FRAC_W);
  localparam int SCORE_W    = 32;
  localparam int MULT_W     = 16;
  localparam int IN_W       = 56;
  localparam int OUT_W      = 24;

  typedef struct packed {
    logic load;
    logic start;
    logic rd_i;
    logic latch_i;
    logic scan;
    logic inc_i;
    logic mul;
    logic chk;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic neg_i;
    logic i_last;
    logic j_last;
    logic pipe_busy;
    logic div_last;
  } sts_t;

endpackage

// ----- sv/wrrs_ctrl.sv -----
// Controller state machine for the weighted ROC AUC rank-sum block.
// Depends on wrrs_pkg; drives the datapath by commands and reads its status.
module wrrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  wrrs_pkg::sts_t    sts,
  output wrrs_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_RDI   = 4'd1;
  localparam logic [3:0] S_LATI  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       acc;

  assign s_tready = (state == S_LOAD);
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_LOAD: begin
        cmd.load = acc;
        if (acc && s_tlast) begin
          cmd.start = 1'b1;
          state_next = S_RDI;
        end
      end
      S_RDI: begin
        cmd.rd_i = 1'b1;
        state_next = S_LATI;
      end
      S_LATI: begin
        cmd.latch_i = 1'b1;
        if (!sts.neg_i) begin
          state_next = S_SCAN;
        end else if (sts.i_last) begin
          state_next = S_MUL;
        end else begin
          cmd.inc_i = 1'b1;
          state_next = S_RDI;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.j_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          if (sts.i_last) begin
            state_next = S_MUL;
          end else begin
            cmd.inc_i = 1'b1;
            state_next = S_RDI;
          end
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/wrrs_dp.sv -----
// Datapath for the weighted ROC AUC rank-sum block: instance memory, pair
// scan with multiply-accumulate, and a restoring divider. Depends on wrrs_pkg.
module wrrs_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  wrrs_pkg::cmd_t                   cmd,
  output wrrs_pkg::sts_t                   sts,
  input  logic [wrrs_pkg::SCORE_W-1:0]     score,
  input  logic                             is_negative,
  input  logic [wrrs_pkg::MULT_W-1:0]      multiplicity,
  output logic [wrrs_pkg::FRAC_W-1:0]      auc_fraction,
  output logic                             degenerate
);

  localparam int CB = wrrs_pkg::COUNT_BITS;
  localparam int AW = wrrs_pkg::ADDR_W;
  localparam int CW = wrrs_pkg::CNT_W;
  localparam int TW = wrrs_pkg::TOT_W;
  localparam int UW = wrrs_pkg::U_W;
  localparam int FW = wrrs_pkg::FRAC_W;

  logic [wrrs_pkg::SCORE_W-1:0] score_mem [wrrs_pkg::MAX_ITEMS];
  logic [CB:0]                  lc_mem    [wrrs_pkg::MAX_ITEMS];

  logic [CW-1:0] cnt;
  logic [TW-1:0] pos_total;
  logic [TW-1:0] neg_total;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [AW-1:0] jq;
  logic [AW-1:0] rd_addr;
  logic [wrrs_pkg::SCORE_W-1:0] rd_score;
  logic [CB:0]   rd_lc;
  logic          rd_v;
  logic [wrrs_pkg::SCORE_W-1:0] ki;
  logic [CB-1:0] ci;
  logic [2*CB-1:0] prod;
  logic          prod_v;
  logic [UW-1:0] u;
  logic [UW-1:0] d;
  logic [UW:0]   r;
  logic [UW:0]   r2;
  logic          sat;
  logic [FW-1:0] frac;
  logic [wrrs_pkg::STEP_W-1:0] step;
  logic          hit;
  logic [FW:0]   rnd;
  logic [CW-1:0] last_idx;

  assign last_idx = cnt - CW'(1);
  assign rd_addr  = cmd.rd_i ? i : j;
  assign hit = rd_lc[CB] && (($signed(rd_score) < $signed(ki)) ||
               ((rd_score == ki) && (jq < i)));
  assign r2  = {r[UW-1:0], 1'b0};
  assign rnd = ({1'b0, frac} + (FW+1)'(1)) >> 1;

  assign sts.neg_i     = rd_lc[CB];
  assign sts.i_last    = ({1'b0, i} == last_idx);
  assign sts.j_last    = ({1'b0, j} == last_idx);
  assign sts.pipe_busy = rd_v || prod_v;
  assign sts.div_last  = (step == wrrs_pkg::STEP_W'(FW - 1));

  always_ff @(posedge clk) begin
    if (cmd.load && (cnt < CW'(wrrs_pkg::MAX_ITEMS))) begin
      score_mem[cnt[AW-1:0]] <= score;
      lc_mem[cnt[AW-1:0]]    <= {is_negative, multiplicity[CB-1:0]};
    end
    rd_score <= score_mem[rd_addr];
    rd_lc    <= lc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pos_total <= '0;
      neg_total <= '0;
      rd_v <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        cnt <= '0;
        pos_total <= '0;
        neg_total <= '0;
      end else if (cmd.load && (cnt < CW'(wrrs_pkg::MAX_ITEMS))) begin
        cnt <= cnt + CW'(1);
        if (is_negative) begin
          neg_total <= neg_total + TW'(multiplicity[CB-1:0]);
        end else begin
          pos_total <= pos_total + TW'(multiplicity[CB-1:0]);
        end
      end
      rd_v <= cmd.scan;
      prod_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i <= '0;
    end else if (cmd.inc_i) begin
      i <= i + AW'(1);
    end
    if (cmd.latch_i) begin
      j  <= '0;
      ki <= rd_score;
      ci <= rd_lc[CB-1:0];
    end else if (cmd.scan) begin
      j <= j + AW'(1);
    end
    jq <= j;
    prod <= hit ? ((2*CB)'(ci) * (2*CB)'(rd_lc[CB-1:0])) : '0;
    if (cmd.start) begin
      u <= '0;
    end else if (prod_v) begin
      u <= u + UW'(prod);
    end
    if (cmd.mul) begin
      d <= UW'(pos_total) * UW'(neg_total);
    end
    if (cmd.chk) begin
      r    <= {1'b0, u};
      sat  <= (u >= d);
      frac <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      if (r2 >= {1'b0, d}) begin
        r    <= r2 - {1'b0, d};
        frac <= {frac[FW-2:0], 1'b1};
      end else begin
        r    <= r2;
        frac <= {frac[FW-2:0], 1'b0};
      end
      step <= step + wrrs_pkg::STEP_W'(1);
    end
    if (cmd.out_load) begin
      degenerate <= (pos_total == '0) || (neg_total == '0);
      if ((pos_total == '0) || (neg_total == '0)) begin
        auc_fraction <= '0;
      end else if (sat) begin
        auc_fraction <= FW'(65536);
      end else begin
        auc_fraction <= rnd[FW-1:0];
      end
    end
  end

endmodule

// ----- sv/weighted_roc_auc_rank_sum.sv -----
// Top level of the weighted ROC AUC rank-sum block.
// Depends on wrrs_pkg, wrrs_ctrl and wrrs_dp.
//
// Instances load at one item per cycle, while the block waits in its load
// state, into a 1024-entry store; later ones are dropped when it is full. The
// item with tlast starts the computation: every stored instance i is read,
// and each positive one scans all n stored entries through the single memory
// read port, one per cycle, accumulating count products of earlier-ranked
// negatives. Then come the product of the totals, a saturation check and the
// 17-step divider. One result item (auc_fraction, degenerate) follows each
// tlast item.
module weighted_roc_auc_rank_sum (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // score[31:0], is_negative[32], multiplicity[48:33], zero fill above.
  input  logic [55:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // auc_fraction[16:0], degenerate[17], zero fill above.
  output logic [23:0] m_tdata
);

  wrrs_pkg::cmd_t cmd;
  wrrs_pkg::sts_t sts;
  logic [wrrs_pkg::FRAC_W-1:0] auc_fraction;
  logic                        degenerate;

  wrrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wrrs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .score        (s_tdata[31:0]),
    .is_negative  (s_tdata[32]),
    .multiplicity (s_tdata[48:33]),
    .auc_fraction (auc_fraction),
    .degenerate   (degenerate)
  );

  assign m_tdata = {6'b0, degenerate, auc_fraction};

endmodule

// ----- dv/wrrs_checker.sv -----
// Checker for the weighted ROC AUC rank-sum block: watches both streams,
// predicts each AUC result from the loaded instances and compares it.
// Depends on wrrs_pkg for the store size and field widths.
`timescale 1ns / 1ps
module wrrs_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          auc_pending,
  output int          auc_checked
);

  typedef struct {
    logic [wrrs_pkg::FRAC_W-1:0] auc;
    logic                        degen;
  } auc_result_t;

  logic signed [wrrs_pkg::SCORE_W-1:0] inst_score [wrrs_pkg::MAX_ITEMS];
  logic                                inst_neg   [wrrs_pkg::MAX_ITEMS];
  logic [wrrs_pkg::COUNT_BITS-1:0]     inst_cnt   [wrrs_pkg::MAX_ITEMS];
  int                                  inst_n;
  auc_result_t                         auc_queue[$];

  assign auc_pending = auc_queue.size();

  function automatic auc_result_t rank_sum_auc();
    auc_result_t                 r;
    longint unsigned             pos_total, neg_total, u, d;
    logic [wrrs_pkg::FRAC_W-1:0] frac;
    pos_total = 0;
    neg_total = 0;
    u = 0;
    frac = '0;
    for (int i = 0; i < inst_n; i++) begin
      if (inst_neg[i]) begin
        neg_total += inst_cnt[i];
        continue;
      end
      pos_total += inst_cnt[i];
      for (int j = 0; j < inst_n; j++) begin
        if (inst_neg[j] && (inst_score[j] < inst_score[i] ||
            (inst_score[j] == inst_score[i] && j < i)))
          u += longint'(inst_cnt[i]) * longint'(inst_cnt[j]);
      end
    end
    r.degen = (pos_total == 0 || neg_total == 0);
    r.auc = '0;
    if (!r.degen) begin
      d = pos_total * neg_total;
      if (u >= d) begin
        r.auc = 17'd65536;
      end else begin
        for (int k = 0; k < wrrs_pkg::FRAC_W; k++) begin
          u = u << 1;
          frac = frac << 1;
          if (u >= d) begin
            u -= d;
            frac[0] = 1'b1;
          end
        end
        r.auc = 17'((18'(frac) + 18'd1) >> 1);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    auc_result_t got, want;
    int          nfail;
    nfail = 0;
    if (rst) begin
      inst_n = 0;
      fail_count <= 0;
      auc_checked <= 0;
      auc_queue.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        if (inst_n < wrrs_pkg::MAX_ITEMS) begin
          inst_score[inst_n] = s_tdata[31:0];
          inst_neg[inst_n]   = s_tdata[32];
          inst_cnt[inst_n]   = s_tdata[48:33];
          inst_n = inst_n + 1;
        end
        if (s_tlast) begin
          auc_queue.push_back(rank_sum_auc());
          inst_n = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        got.auc = m_tdata[16:0];
        got.degen = m_tdata[17];
        if (auc_queue.size() == 0) begin
          $error("unexpected result item auc_fraction=%0d degenerate=%0b",
                 got.auc, got.degen);
          nfail = nfail + 1;
        end else begin
          want = auc_queue.pop_front();
          auc_checked <= auc_checked + 1;
          if (got.auc !== want.auc) begin
            $error("auc_fraction: expected %0d, got %0d", want.auc, got.auc);
            nfail = nfail + 1;
          end
          if (got.degen !== want.degen) begin
            $error("degenerate: expected %0b, got %0b", want.degen, got.degen);
            nfail = nfail + 1;
          end
        end
      end
      fail_count <= fail_count + nfail;
    end
  end

endmodule

// ----- dv/tb_weighted_roc_auc_rank_sum.sv -----
// Testbench top for the weighted ROC AUC rank-sum block: drives scored
// instance sets in bursts, stalls the result side, and reports the verdict.
// Depends on wrrs_pkg, weighted_roc_auc_rank_sum and wrrs_checker.
`timescale 1ns / 1ps
module tb_weighted_roc_auc_rank_sum;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  int          fail_count;
  int          auc_pending;
  int          auc_checked;
  int          burst_left;
  int          items_sent;
  int          sets_sent;
  logic        hold_off_done;

  weighted_roc_auc_rank_sum DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  wrrs_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .auc_pending(auc_pending), .auc_checked(auc_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_weighted_roc_auc_rank_sum: errors");
    $finish;
  end

  // The result side first holds off for a long stretch so the block backs up,
  // then alternates between random stalls and fully ready stretches.
  initial begin
    int mode;
    m_tready = 1'b0;
    hold_off_done = 1'b0;
    @(negedge rst);
    repeat (3000) @(posedge clk);
    hold_off_done = 1'b1;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(16, 96)) begin
        m_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode * 2) == 0);
        @(posedge clk);
      end
    end
  end

  task automatic offer(input logic [31:0] score, input logic neg,
                       input logic [15:0] mult, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, mult, neg, score};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    items_sent++;
    if (last)
      sets_sent++;
  endtask

  function automatic logic [31:0] pick_score(input bit tie_pool);
    logic [31:0] pool [5] = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h7FFF_FFFF};
    if (tie_pool)
      return pool[$urandom_range(0, 4)];
    return $urandom();
  endfunction

  function automatic logic [15:0] pick_mult();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_set(input int len, input bit tie_pool);
    for (int k = 0; k < len; k++)
      offer(pick_score(tie_pool), 1'($urandom_range(0, 1)), pick_mult(), k == len - 1);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    burst_left = 0;
    items_sent = 0;
    sets_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single positive, then single negative: both degenerate.
    offer(32'h0001_0000, 1'b0, 16'd5, 1'b1);
    offer(32'h0001_0000, 1'b1, 16'd5, 1'b1);
    // Negative below positive at the score extremes, full counts: AUC of one.
    offer(32'h8000_0000, 1'b1, 16'hFFFF, 1'b0);
    offer(32'h7FFF_FFFF, 1'b0, 16'hFFFF, 1'b1);
    // Reversed order: AUC of zero.
    offer(32'h8000_0000, 1'b0, 16'hFFFF, 1'b0);
    offer(32'h7FFF_FFFF, 1'b1, 16'hFFFF, 1'b1);
    // Equal scores rank in arrival order, both ways round.
    offer(32'h0, 1'b1, 16'd3, 1'b0);
    offer(32'h0, 1'b0, 16'd7, 1'b1);
    offer(32'hFFFF_FFFF, 1'b0, 16'd7, 1'b0);
    offer(32'hFFFF_FFFF, 1'b1, 16'd3, 1'b1);
    // Zero multiplicity on the only negative makes the set degenerate.
    offer(32'h0000_0010, 1'b1, 16'd0, 1'b0);
    offer(32'h0000_0020, 1'b0, 16'd9, 1'b1);
    // Mixed set with a non-trivial fraction and a zero-count positive.
    offer(32'hFFFF_0000, 1'b1, 16'd2, 1'b0);
    offer(32'h0000_8000, 1'b0, 16'd3, 1'b0);
    offer(32'h0000_4000, 1'b1, 16'd5, 1'b0);
    offer(32'h0002_0000, 1'b0, 16'd0, 1'b0);
    offer(32'hAAAA_5555, 1'b0, 16'd1, 1'b1);

    // Random sets, mostly short; the early ones run into the result hold-off.
    while (items_sent < 640)
      random_set($urandom_range(1, 12), $urandom_range(0, 2) == 0);

    // Overfilled store: mostly negatives, a few positives, and extras dropped.
    for (int k = 0; k < wrrs_pkg::MAX_ITEMS + 6; k++)
      offer(pick_score(k[0]), !(k % 400 == 7), pick_mult(), k == wrrs_pkg::MAX_ITEMS + 5);

    while (items_sent < 1700)
      random_set($urandom_range(1, 12), $urandom_range(0, 2) == 0);

    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    while (auc_pending != 0 || !hold_off_done) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d instances in %0d sets, including an overfilled store;",
             items_sent, sets_sent);
    $display("checked %0d AUC results against the predicted rank sums.", auc_checked);
    if (fail_count == 0 && auc_pending == 0)
      $display("tb_weighted_roc_auc_rank_sum: clean");
    else
      $display("tb_weighted_roc_auc_rank_sum: errors");
    $finish;
  end

endmodule
